// ===== hdl/tsp_pkg.sv =====
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types and constants for the text space/punctuation compactor.
// ----------------------------------------------------------------------------
package tsp_pkg;

  // Byte and set geometry
  localparam int CHAR_W        = 8;
  localparam int SET_SIZE      = 8;
  localparam int SET_W         = SET_SIZE * CHAR_W;
  localparam int SIZE_W        = 4;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;

  // Punctuation run counter
  localparam int PUNCT_RUN_MAX = 63;
  localparam int CNT_W         = $clog2(PUNCT_RUN_MAX + 1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PUNCT_SET  = 3'd0,
    REG_PUNCT_SIZE = 3'd1,
    REG_SPACE_SET  = 3'd2,
    REG_SPACE_SIZE = 3'd3,
    REG_TRASH_SET  = 3'd4,
    REG_TRASH_SIZE = 3'd5
  } cfg_idx_e;

  // Byte classes, in priority order after end of string
  typedef enum logic [2:0] {
    CLS_END,
    CLS_PUNCT,
    CLS_SPACE,
    CLS_TRASH,
    CLS_OTHER
  } char_class_e;

  // Configuration register bank
  typedef struct packed {
    logic [SET_W-1:0]  punct_set;
    logic [SIZE_W-1:0] punct_size;
    logic [SET_W-1:0]  space_set;
    logic [SIZE_W-1:0] space_size;
    logic [SET_W-1:0]  trash_set;
    logic [SIZE_W-1:0] trash_size;
  } cfg_t;

  // One output job: fill_cnt copies of fill_char, then last_char
  typedef struct packed {
    logic [CHAR_W-1:0] fill_char;
    logic [CNT_W-1:0]  fill_cnt;
    logic [CHAR_W-1:0] last_char;
  } job_t;

endpackage

// ===== hdl/tsp_set_match.sv =====
// ----------------------------------------------------------------------------
// tsp_set_match
// Compares one byte against the valid entries of a packed byte set.
// ----------------------------------------------------------------------------
module tsp_set_match
  import tsp_pkg::*;
(
  input  logic [SET_W-1:0]  set_i,
  input  logic [SIZE_W-1:0] size_i,
  input  logic [CHAR_W-1:0] char_i,
  output logic              hit_o
);

  logic [SIZE_W-1:0] n_valid;

  // Sizes above the set capacity count as full
  assign n_valid = (size_i > SIZE_W'(SET_SIZE)) ? SIZE_W'(SET_SIZE) : size_i;

  // Parallel compare over all entries
  always_comb begin
    hit_o = 1'b0;
    for (int i = 0; i < SET_SIZE; i++) begin
      if ((SIZE_W'(i) < n_valid) && (set_i[i*CHAR_W +: CHAR_W] == char_i)) begin
        hit_o = 1'b1;
      end
    end
  end

endmodule

// ===== hdl/tsp_classify.sv =====
// ----------------------------------------------------------------------------
// tsp_classify
// Input register, byte classing and pending state; issues output jobs.
// ----------------------------------------------------------------------------
module tsp_classify
  import tsp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [CHAR_W-1:0] in_char_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output job_t              job_o
);

  logic              in_valid_q, in_valid_d;
  logic [CHAR_W-1:0] in_char_q, in_char_d;
  logic [CNT_W-1:0]  punct_pend_q, punct_pend_d;
  logic              space_pend_q, space_pend_d;
  logic              started_q, started_d;

  logic              hit_punct, hit_space, hit_trash;
  char_class_e       cls;
  logic              gen_job;
  logic              in_take;

  // Set matchers
  tsp_set_match u_match_punct (
    .set_i  (cfg_i.punct_set),
    .size_i (cfg_i.punct_size),
    .char_i (in_char_q),
    .hit_o  (hit_punct)
  );

  tsp_set_match u_match_space (
    .set_i  (cfg_i.space_set),
    .size_i (cfg_i.space_size),
    .char_i (in_char_q),
    .hit_o  (hit_space)
  );

  tsp_set_match u_match_trash (
    .set_i  (cfg_i.trash_set),
    .size_i (cfg_i.trash_size),
    .char_i (in_char_q),
    .hit_o  (hit_trash)
  );

  // Priority classing
  always_comb begin
    if (in_char_q == '0)  cls = CLS_END;
    else if (hit_punct)   cls = CLS_PUNCT;
    else if (hit_space)   cls = CLS_SPACE;
    else if (hit_trash)   cls = CLS_TRASH;
    else                  cls = CLS_OTHER;
  end

  // Only end and other bytes produce output beats
  assign gen_job     = (cls == CLS_END) || (cls == CLS_OTHER);
  assign in_take     = in_valid_q && (!gen_job || job_ready_i);
  assign in_stall_o  = in_valid_q && !in_take;
  assign job_valid_o = in_valid_q && gen_job;

  // Job contents: flush only after output has begun
  always_comb begin
    job_o.last_char = in_char_q;
    job_o.fill_char = (punct_pend_q != '0) ? cfg_i.punct_set[CHAR_W-1:0]
                                           : cfg_i.space_set[CHAR_W-1:0];
    if (!started_q || cls == CLS_END) begin
      job_o.fill_cnt = '0;
    end else if (punct_pend_q != '0) begin
      job_o.fill_cnt = punct_pend_q;
    end else begin
      job_o.fill_cnt = CNT_W'(space_pend_q);
    end
  end

  // Input register
  always_comb begin
    in_valid_d = in_valid_q;
    in_char_d  = in_char_q;
    if (in_valid_i && !in_stall_o) begin
      in_valid_d = 1'b1;
      in_char_d  = in_char_i;
    end else if (in_take) begin
      in_valid_d = 1'b0;
    end
  end

  // Pending state update
  always_comb begin
    punct_pend_d = punct_pend_q;
    space_pend_d = space_pend_q;
    started_d    = started_q;
    if (in_take) begin
      case (cls)
        CLS_END: begin
          punct_pend_d = '0;
          space_pend_d = 1'b0;
          started_d    = 1'b0;
        end
        CLS_PUNCT: begin
          if (punct_pend_q < CNT_W'(PUNCT_RUN_MAX)) punct_pend_d = punct_pend_q + 1'b1;
        end
        CLS_SPACE: begin
          space_pend_d = 1'b1;
        end
        CLS_OTHER: begin
          punct_pend_d = '0;
          space_pend_d = 1'b0;
          started_d    = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      punct_pend_q <= '0;
      space_pend_q <= 1'b0;
      started_q    <= 1'b0;
    end else begin
      in_valid_q   <= in_valid_d;
      punct_pend_q <= punct_pend_d;
      space_pend_q <= space_pend_d;
      started_q    <= started_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    in_char_q <= in_char_d;
  end

endmodule

// ===== hdl/tsp_emitter.sv =====
// ----------------------------------------------------------------------------
// tsp_emitter
// Holds one output job and plays it out beat by beat into the output register.
// ----------------------------------------------------------------------------
module tsp_emitter
  import tsp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  job_t              job_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CHAR_W-1:0] out_char_o,
  output logic              run_last_o
);

  logic              job_valid_q, job_valid_d;
  job_t              job_q, job_d;
  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_char_q, out_char_d;
  logic              run_last_q, run_last_d;
  logic              out_load;
  logic              job_done;

  // Output register can take a beat when empty or draining
  assign out_load    = !out_valid_q || !out_stall_i;
  assign job_done    = job_valid_q && out_load && (job_q.fill_cnt == '0);
  assign job_ready_o = !job_valid_q || job_done;

  // Job slot and output beat
  always_comb begin
    job_valid_d = job_valid_q;
    job_d       = job_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    run_last_d  = run_last_q;
    if (out_load) begin
      out_valid_d = job_valid_q;
      if (job_valid_q) begin
        if (job_q.fill_cnt != '0) begin
          out_char_d     = job_q.fill_char;
          run_last_d     = 1'b0;
          job_d.fill_cnt = job_q.fill_cnt - 1'b1;
        end else begin
          out_char_d  = job_q.last_char;
          run_last_d  = 1'b1;
          job_valid_d = 1'b0;
        end
      end
    end
    if (job_valid_i && job_ready_o) begin
      job_valid_d = 1'b1;
      job_d       = job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    out_char_q <= out_char_d;
    run_last_q <= run_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign run_last_o  = run_last_q;

endmodule

// ===== hdl/text_space_punct_compactor.sv =====
// ----------------------------------------------------------------------------
// text_space_punct_compactor
// Squeezes a byte stream: collapses punctuation and space runs, drops trash.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in       input      in_valid_i/in_stall_o  in_char_i
//  out      output     out_valid_o/out_stall_i out_char_o, run_last_o
//  cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  One input byte per cycle while in_stall_o is low. An other byte that
//  flushes a run of N pending punctuation or space replacements takes N+1
//  output beats; the output job slot plays those out one per cycle unless
//  the output stalls. Beats pass the input register, job slot and output register.
//  Reset (rst_ni, async, active low) clears config, pending state and valids.
//  Output stall holds the output register; input stalls once the job slot
//  is busy and the input register holds an end or other byte.
// ----------------------------------------------------------------------------
module text_space_punct_compactor
  import tsp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CHAR_W-1:0]     in_char_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CHAR_W-1:0]     out_char_o,
  output logic                  run_last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  logic job_valid;
  logic job_ready;
  job_t job;

  assign cfg_ready_o = 1'b1;

  // Configuration register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_PUNCT_SET:  cfg_d.punct_set  = cfg_data_i[SET_W-1:0];
        REG_PUNCT_SIZE: cfg_d.punct_size = cfg_data_i[SIZE_W-1:0];
        REG_SPACE_SET:  cfg_d.space_set  = cfg_data_i[SET_W-1:0];
        REG_SPACE_SIZE: cfg_d.space_size = cfg_data_i[SIZE_W-1:0];
        REG_TRASH_SET:  cfg_d.trash_set  = cfg_data_i[SET_W-1:0];
        REG_TRASH_SIZE: cfg_d.trash_size = cfg_data_i[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Classing and pending state
  tsp_classify u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_char_i   (in_char_i),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  // Beat generation
  tsp_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_char_o  (out_char_o),
    .run_last_o  (run_last_o)
  );

endmodule
